@@ rtl/ljpf_pkg.sv @@
// Shared types, register codes and arithmetic helpers of the pair force accumulator.
package ljpf_pkg;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_PAIR = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic [2:0] CFG_BOX_X     = 3'd0;
    localparam logic [2:0] CFG_BOX_Y     = 3'd1;
    localparam logic [2:0] CFG_BOX_Z     = 3'd2;
    localparam logic [2:0] CFG_INV_BOX_X = 3'd3;
    localparam logic [2:0] CFG_INV_BOX_Y = 3'd4;
    localparam logic [2:0] CFG_INV_BOX_Z = 3'd5;
    localparam logic [2:0] CFG_CUTOFF_SQ = 3'd6;
    localparam logic [2:0] CFG_SIGMA_SQ  = 3'd7;

    localparam logic [63:0] CAP64    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S2_LIMIT = 64'h0000_0200_0000_0000;
    localparam logic [63:0] AB_LIMIT = CAP64 / 64'd12;
    localparam logic [47:0] FMAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] FMIN     = 48'h8000_0000_0000;

    typedef struct packed {
        logic [30:0] box_x;
        logic [30:0] box_y;
        logic [30:0] box_z;
        logic [30:0] inv_box_x;
        logic [30:0] inv_box_y;
        logic [30:0] inv_box_z;
        logic [30:0] cutoff_sq;
        logic [30:0] sigma_sq;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pos;

    typedef struct packed {
        logic               sat;
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic signed [47:0] z;
    } t_force;

    typedef struct packed {
        logic               update;
        logic               clamp;
        logic signed [47:0] fx;
        logic signed [47:0] fy;
        logic signed [47:0] fz;
    } t_pair_res;

    // Product shifted right and capped at the largest signed 64-bit value.
    function automatic logic [63:0] capsh(input logic [127:0] p, input int unsigned sh);
        logic [127:0] v;
        v = p >> sh;
        return (|v[127:63]) ? CAP64 : v[63:0];
    endfunction

    // Saturating 48-bit add; the top bit of the result flags a clamp.
    function automatic logic [48:0] sat_add(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (!s[48] && s[47]) begin
            return {1'b1, FMAX};
        end else if (s[48] && !s[47]) begin
            return {1'b1, FMIN};
        end
        return {1'b0, s[47:0]};
    endfunction

endpackage

@@ rtl/ljpf_mul.sv @@
// 64 by 64 bit multiplier built from one 32 by 32 bit product per cycle.
module ljpf_mul import ljpf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic         r_pp_v;
    logic         r_done;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [63:0]  r_pp;
    logic [1:0]   r_pos;
    logic [127:0] r_acc;
    logic [31:0]  a_h;
    logic [31:0]  b_h;
    logic [127:0] pp_sh;

    always_comb begin
        a_h = r_cnt[0] ? r_a[63:32] : r_a[31:0];
        b_h = r_cnt[1] ? r_b[63:32] : r_b[31:0];
        case (r_pos)
            2'd0:    pp_sh = {64'd0, r_pp};
            2'd1:    pp_sh = {32'd0, r_pp, 32'd0};
            default: pp_sh = {r_pp, 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_pp_v <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_pp_v <= r_busy && (r_cnt < 3'd4) && !i_start;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                if (r_cnt < 3'd4) begin
                    r_cnt <= r_cnt + 3'd1;
                end
                if (r_pp_v && r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= 128'd0;
        end else begin
            if (r_busy && r_cnt < 3'd4) begin
                r_pp  <= a_h * b_h;
                r_pos <= {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
            end
            if (r_pp_v) begin
                r_acc <= r_acc + pp_sh;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ rtl/ljpf_div.sv @@
// Restoring divider that forms 2^56 / d one quotient bit per cycle.
module ljpf_div import ljpf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_d,
    output logic        o_done,
    output logic [56:0] o_q
);

    localparam int QW = 57;

    logic          r_busy;
    logic          r_done;
    logic [5:0]    r_cnt;
    logic [QW-1:0] r_num;
    logic [30:0]   r_rem;
    logic [QW-1:0] r_q;
    logic [30:0]   r_d;
    logic [31:0]   rem2;
    logic [31:0]   rem_nx;
    logic          ge;

    always_comb begin
        rem2   = {r_rem, r_num[QW-1]};
        ge     = rem2 >= {1'b0, r_d};
        rem_nx = ge ? rem2 - {1'b0, r_d} : rem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {1'b1, {(QW-1){1'b0}}};
            r_rem <= 31'd0;
            r_q   <= '0;
            r_d   <= i_d;
        end else if (r_busy) begin
            r_num <= {r_num[QW-2:0], 1'b0};
            r_rem <= rem_nx[30:0];
            r_q   <= {r_q[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

@@ rtl/ljpf_math.sv @@
// Sequencer for the minimum image, the cutoff test and the Lennard-Jones force of one pair.
module ljpf_math import ljpf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_pos      i_pos_i,
    input  t_pos      i_pos_j,
    input  t_cfg      i_cfg,
    output logic      o_done,
    output t_pair_res o_res
);

    localparam logic [3:0] M_IDLE = 4'd0;
    localparam logic [3:0] M_DSUB = 4'd1;
    localparam logic [3:0] M_IMGN = 4'd2;
    localparam logic [3:0] M_IMGR = 4'd3;
    localparam logic [3:0] M_SQ   = 4'd4;
    localparam logic [3:0] M_R2   = 4'd5;
    localparam logic [3:0] M_DIV  = 4'd6;
    localparam logic [3:0] M_S2   = 4'd7;
    localparam logic [3:0] M_S4   = 4'd8;
    localparam logic [3:0] M_S6   = 4'd9;
    localparam logic [3:0] M_A    = 4'd10;
    localparam logic [3:0] M_AB   = 4'd11;
    localparam logic [3:0] M_COMP = 4'd12;
    localparam logic [3:0] M_CMUL = 4'd13;
    localparam logic [3:0] M_DONE = 4'd14;

    logic [3:0]   r_state;
    logic [1:0]   r_ax;
    t_pos         r_pi;
    t_pos         r_pj;
    logic         r_dneg;
    logic [32:0]  r_dmag;
    logic [27:0]  r_mag [3];
    logic         r_neg [3];
    logic [47:0]  r_f [3];
    logic [57:0]  r_rsq;
    logic [56:0]  r_ir;
    logic [63:0]  r_s2;
    logic [63:0]  r_b;
    logic [63:0]  r_fr;
    logic         r_huge;
    logic         r_frneg;
    logic         r_clamp;
    logic         r_update;
    logic         r_done;
    logic         r_mul_start;
    logic [63:0]  r_mul_a;
    logic [63:0]  r_mul_b;
    logic         r_div_start;
    logic [30:0]  r_div_d;

    logic         mul_done;
    logic [127:0] prod;
    logic         div_done;
    logic [56:0]  div_q;

    logic [31:0]  pi_k;
    logic [31:0]  pj_k;
    logic [30:0]  box_k;
    logic [30:0]  inv_k;
    logic [32:0]  d_sub;
    logic [32:0]  d_mag;
    logic [64:0]  img_sum;
    logic [49:0]  rs;
    logic [49:0]  dk;
    logic [49:0]  kmag;
    logic [33:0]  r2;
    logic [63:0]  cap16;
    logic [63:0]  cap24;
    logic [63:0]  cap32;
    logic [63:0]  cap48;
    logic [63:0]  two;
    logic [63:0]  ab12;
    logic         m_big;
    logic [47:0]  f_mag;
    logic [47:0]  f_val;

    ljpf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    ljpf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_d     (r_div_d),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    always_comb begin
        case (r_ax)
            2'd0: begin
                pi_k  = r_pi.x;
                pj_k  = r_pj.x;
                box_k = i_cfg.box_x;
                inv_k = i_cfg.inv_box_x;
            end
            2'd1: begin
                pi_k  = r_pi.y;
                pj_k  = r_pj.y;
                box_k = i_cfg.box_y;
                inv_k = i_cfg.inv_box_y;
            end
            default: begin
                pi_k  = r_pi.z;
                pj_k  = r_pj.z;
                box_k = i_cfg.box_z;
                inv_k = i_cfg.inv_box_z;
            end
        endcase
        d_sub   = {pi_k[31], pi_k} - {pj_k[31], pj_k};
        d_mag   = d_sub[32] ? (33'd0 - d_sub) : d_sub;
        // Round to nearest with ties away from zero on the magnitude.
        img_sum = {1'b0, prod[63:0]} + 65'h0_0000_8000_0000_0000;
        rs      = {17'd0, r_dmag} - {2'd0, prod[47:0]};
        dk      = r_dneg ? (50'd0 - rs) : rs;
        kmag    = dk[49] ? (50'd0 - dk) : dk;
        r2      = r_rsq[57:24];
        cap16   = capsh(prod, 16);
        cap24   = capsh(prod, 24);
        cap32   = capsh(prod, 32);
        cap48   = capsh(prod, 48);
        two     = {cap32[62:0], 1'b0};
        ab12    = {cap32[60:0], 3'd0} + {cap32[61:0], 2'd0};
        m_big   = cap16 > {16'd0, FMAX};
        f_mag   = (r_huge || m_big) ? FMAX : cap16[47:0];
        f_val   = (r_neg[r_ax] != r_frneg) ? (48'd0 - f_mag) : f_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= M_IDLE;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_done      <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_pi    <= i_pos_i;
                        r_pj    <= i_pos_j;
                        r_ax    <= 2'd0;
                        r_rsq   <= 58'd0;
                        r_huge  <= 1'b0;
                        r_frneg <= 1'b0;
                        r_clamp <= 1'b0;
                        r_state <= M_DSUB;
                    end
                end
                M_DSUB: begin
                    r_dneg      <= d_sub[32];
                    r_dmag      <= d_mag;
                    r_mul_a     <= {31'd0, d_mag};
                    r_mul_b     <= {33'd0, inv_k};
                    r_mul_start <= 1'b1;
                    r_state     <= M_IMGN;
                end
                M_IMGN: begin
                    if (mul_done) begin
                        r_mul_a     <= {47'd0, img_sum[64:48]};
                        r_mul_b     <= {33'd0, box_k};
                        r_mul_start <= 1'b1;
                        r_state     <= M_IMGR;
                    end
                end
                M_IMGR: begin
                    if (mul_done) begin
                        if (|kmag[49:28]) begin
                            r_update <= 1'b0;
                            r_state  <= M_DONE;
                        end else begin
                            r_mag[r_ax] <= kmag[27:0];
                            r_neg[r_ax] <= dk[49];
                            r_mul_a     <= {36'd0, kmag[27:0]};
                            r_mul_b     <= {36'd0, kmag[27:0]};
                            r_mul_start <= 1'b1;
                            r_state     <= M_SQ;
                        end
                    end
                end
                M_SQ: begin
                    if (mul_done) begin
                        r_rsq <= r_rsq + prod[57:0];
                        if (r_ax == 2'd2) begin
                            r_state <= M_R2;
                        end else begin
                            r_ax    <= r_ax + 2'd1;
                            r_state <= M_DSUB;
                        end
                    end
                end
                M_R2: begin
                    if (r2 == 34'd0 || r2 >= {3'd0, i_cfg.cutoff_sq}) begin
                        r_update <= 1'b0;
                        r_state  <= M_DONE;
                    end else begin
                        r_div_d     <= r2[30:0];
                        r_div_start <= 1'b1;
                        r_state     <= M_DIV;
                    end
                end
                M_DIV: begin
                    if (div_done) begin
                        r_ir        <= div_q;
                        r_mul_a     <= {33'd0, i_cfg.sigma_sq};
                        r_mul_b     <= {7'd0, div_q};
                        r_mul_start <= 1'b1;
                        r_state     <= M_S2;
                    end
                end
                M_S2: begin
                    if (mul_done) begin
                        if (cap24 >= S2_LIMIT) begin
                            r_huge  <= 1'b1;
                            r_frneg <= 1'b0;
                            r_ax    <= 2'd0;
                            r_state <= M_COMP;
                        end else begin
                            r_s2        <= cap24;
                            r_mul_a     <= cap24;
                            r_mul_b     <= cap24;
                            r_mul_start <= 1'b1;
                            r_state     <= M_S4;
                        end
                    end
                end
                M_S4: begin
                    if (mul_done) begin
                        r_mul_a     <= prod[95:32];
                        r_mul_b     <= r_s2;
                        r_mul_start <= 1'b1;
                        r_state     <= M_S6;
                    end
                end
                M_S6: begin
                    if (mul_done) begin
                        // The sign of 2*s^6 - 1 is the sign of the force scalar.
                        if (two >= 64'h1_0000_0000) begin
                            r_b     <= two - 64'h1_0000_0000;
                            r_frneg <= 1'b0;
                        end else begin
                            r_b     <= 64'h1_0000_0000 - two;
                            r_frneg <= 1'b1;
                        end
                        r_mul_a     <= cap32;
                        r_mul_b     <= {7'd0, r_ir};
                        r_mul_start <= 1'b1;
                        r_state     <= M_A;
                    end
                end
                M_A: begin
                    if (mul_done) begin
                        r_mul_a     <= cap48;
                        r_mul_b     <= r_b;
                        r_mul_start <= 1'b1;
                        r_state     <= M_AB;
                    end
                end
                M_AB: begin
                    if (mul_done) begin
                        if (cap32 > AB_LIMIT) begin
                            r_huge  <= 1'b1;
                            r_frneg <= 1'b0;
                        end else begin
                            r_fr <= ab12;
                        end
                        r_ax    <= 2'd0;
                        r_state <= M_COMP;
                    end
                end
                M_COMP: begin
                    if (r_mag[r_ax] == 28'd0 || r_huge) begin
                        if (r_mag[r_ax] == 28'd0) begin
                            r_f[r_ax] <= 48'd0;
                        end else begin
                            r_f[r_ax] <= f_val;
                            r_clamp   <= 1'b1;
                        end
                        if (r_ax == 2'd2) begin
                            r_update <= 1'b1;
                            r_state  <= M_DONE;
                        end else begin
                            r_ax <= r_ax + 2'd1;
                        end
                    end else begin
                        r_mul_a     <= r_fr;
                        r_mul_b     <= {36'd0, r_mag[r_ax]};
                        r_mul_start <= 1'b1;
                        r_state     <= M_CMUL;
                    end
                end
                M_CMUL: begin
                    if (mul_done) begin
                        r_f[r_ax] <= f_val;
                        if (m_big) begin
                            r_clamp <= 1'b1;
                        end
                        if (r_ax == 2'd2) begin
                            r_update <= 1'b1;
                            r_state  <= M_DONE;
                        end else begin
                            r_ax    <= r_ax + 2'd1;
                            r_state <= M_COMP;
                        end
                    end
                end
                M_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_res.update = r_update;
    assign o_res.clamp  = r_clamp;
    assign o_res.fx     = r_f[0];
    assign o_res.fy     = r_f[1];
    assign o_res.fz     = r_f[2];

endmodule

@@ rtl/ljpf_mem.sv @@
// Position and force stores, each one write port and one registered read port.
module ljpf_mem import ljpf_pkg::*; #(
    parameter int ATOMS = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_pos_we,
    input  logic [AW-1:0] i_pos_waddr,
    input  t_pos          i_pos_wdata,
    input  logic [AW-1:0] i_pos_raddr,
    output t_pos          o_pos_rdata,
    input  logic          i_force_we,
    input  logic [AW-1:0] i_force_waddr,
    input  t_force        i_force_wdata,
    input  logic [AW-1:0] i_force_raddr,
    output t_force        o_force_rdata
);

    t_pos   pos_mem   [ATOMS];
    t_force force_mem [ATOMS];
    t_pos   r_pos_rd;
    t_force r_force_rd;

    always_ff @(posedge i_clk) begin
        if (i_pos_we) begin
            pos_mem[i_pos_waddr] <= i_pos_wdata;
        end
        r_pos_rd <= pos_mem[i_pos_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_force_we) begin
            force_mem[i_force_waddr] <= i_force_wdata;
        end
        r_force_rd <= force_mem[i_force_raddr];
    end

    assign o_pos_rdata   = r_pos_rd;
    assign o_force_rdata = r_force_rd;

endmodule

@@ rtl/lj_pair_force_accumulator_top.sv @@
// Lennard-Jones pair force accumulator: control, configuration and result register.
//
// Items enter on a valid/ready input channel; req_type selects a load (position written,
// force and saturation flag cleared), a pair interaction or a force read. Only reads give
// a beat on the valid/ready output channel. Configuration registers are written through
// a plain write port (enable, index, data); the user must write them only while the block
// is idle, which the block does not enforce. A read passes the registered force store
// read into the output register. A pair within the cutoff runs two position reads,
// seventeen passes through the shared 64 by 64 bit multiplier (four 32 by 32 bit partial
// products each), a quotient loop for the reciprocal of r^2, then a read-modify-write
// of each atom's force. A pair that falls outside the cutoff finishes sooner.
// One item is in work at a time; the next is taken once the current one has finished.
// A read result waits in the output register while the receiver stalls; further items
// are accepted meanwhile, and a second read holds in the block until the register frees.
// Synchronous reset returns the controller to idle, empties the output register and
// loads the configuration defaults. Stores are undefined until an atom is loaded.
module lj_pair_force_accumulator_top import ljpf_pkg::*; #(
    parameter int ATOMS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_atom_a,
    input  logic [11:0] i_atom_b,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_atom_index,
    output logic [47:0] o_force_x,
    output logic [47:0] o_force_y,
    output logic [47:0] o_force_z,
    output logic        o_force_saturated,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);

    localparam int AW = $clog2(ATOMS);

    localparam logic [2:0] T_IDLE   = 3'd0;
    localparam logic [2:0] T_PB     = 3'd1;
    localparam logic [2:0] T_MSTART = 3'd2;
    localparam logic [2:0] T_MWAIT  = 3'd3;
    localparam logic [2:0] T_FI     = 3'd4;
    localparam logic [2:0] T_FJ     = 3'd5;
    localparam logic [2:0] T_RD     = 3'd6;

    logic [2:0]    r_state;
    t_cfg          r_cfg;
    logic [11:0]   r_a;
    logic [11:0]   r_b;
    t_pos          r_pos_a;
    t_pair_res     r_res;
    logic          r_out_valid;
    logic [11:0]   r_out_idx;
    t_force        r_out;

    logic          accept;
    logic          a_ok;
    logic          b_ok;
    logic [AW-1:0] a_addr;
    logic [AW-1:0] ra_addr;
    logic [AW-1:0] rb_addr;
    logic          out_load;

    logic          pos_we;
    t_pos          pos_wdata;
    logic [AW-1:0] pos_raddr;
    t_pos          pos_rd;
    logic          force_we;
    logic [AW-1:0] force_waddr;
    t_force        force_wdata;
    logic [AW-1:0] force_raddr;
    t_force        force_rd;

    logic          math_done;
    t_pair_res     math_res;

    logic [47:0]   vx;
    logic [47:0]   vy;
    logic [47:0]   vz;
    logic [48:0]   sx;
    logic [48:0]   sy;
    logic [48:0]   sz;

    assign o_in_ready = (r_state == T_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign a_ok       = 32'(i_atom_a) < ATOMS;
    assign b_ok       = 32'(i_atom_b) < ATOMS;
    assign a_addr     = AW'(i_atom_a);
    assign ra_addr    = AW'(r_a);
    assign rb_addr    = AW'(r_b);
    assign out_load   = (r_state == T_RD) && (!r_out_valid || i_out_ready);

    always_comb begin
        // Atom j receives the opposite of the pair force.
        vx = (r_state == T_FJ) ? (48'd0 - r_res.fx) : r_res.fx;
        vy = (r_state == T_FJ) ? (48'd0 - r_res.fy) : r_res.fy;
        vz = (r_state == T_FJ) ? (48'd0 - r_res.fz) : r_res.fz;
        sx = sat_add(force_rd.x, vx);
        sy = sat_add(force_rd.y, vy);
        sz = sat_add(force_rd.z, vz);

        pos_we      = accept && (i_req_type == REQ_LOAD) && a_ok;
        pos_wdata.x = i_pos_x;
        pos_wdata.y = i_pos_y;
        pos_wdata.z = i_pos_z;
        pos_raddr   = (r_state == T_IDLE) ? a_addr : rb_addr;

        force_raddr = (r_state == T_IDLE) ? a_addr : ((r_state == T_FI) ? rb_addr : ra_addr);
        if (r_state == T_FI || r_state == T_FJ) begin
            force_we          = 1'b1;
            force_waddr       = (r_state == T_FI) ? ra_addr : rb_addr;
            force_wdata.sat   = force_rd.sat | r_res.clamp | sx[48] | sy[48] | sz[48];
            force_wdata.x     = sx[47:0];
            force_wdata.y     = sy[47:0];
            force_wdata.z     = sz[47:0];
        end else begin
            force_we          = pos_we;
            force_waddr       = a_addr;
            force_wdata       = '0;
        end
    end

    ljpf_mem #(
        .ATOMS (ATOMS),
        .AW    (AW)
    ) u_mem (
        .i_clk         (i_clk),
        .i_pos_we      (pos_we),
        .i_pos_waddr   (a_addr),
        .i_pos_wdata   (pos_wdata),
        .i_pos_raddr   (pos_raddr),
        .o_pos_rdata   (pos_rd),
        .i_force_we    (force_we),
        .i_force_waddr (force_waddr),
        .i_force_wdata (force_wdata),
        .i_force_raddr (force_raddr),
        .o_force_rdata (force_rd)
    );

    ljpf_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == T_MSTART),
        .i_pos_i (r_pos_a),
        .i_pos_j (pos_rd),
        .i_cfg   (r_cfg),
        .o_done  (math_done),
        .o_res   (math_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_x     <= 31'd100663296;
            r_cfg.box_y     <= 31'd100663296;
            r_cfg.box_z     <= 31'd100663296;
            r_cfg.inv_box_x <= 31'd2796203;
            r_cfg.inv_box_y <= 31'd2796203;
            r_cfg.inv_box_z <= 31'd2796203;
            r_cfg.cutoff_sq <= 31'd16777216;
            r_cfg.sigma_sq  <= 31'd1509949;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BOX_X:     r_cfg.box_x     <= i_cfg_data;
                CFG_BOX_Y:     r_cfg.box_y     <= i_cfg_data;
                CFG_BOX_Z:     r_cfg.box_z     <= i_cfg_data;
                CFG_INV_BOX_X: r_cfg.inv_box_x <= i_cfg_data;
                CFG_INV_BOX_Y: r_cfg.inv_box_y <= i_cfg_data;
                CFG_INV_BOX_Z: r_cfg.inv_box_z <= i_cfg_data;
                CFG_CUTOFF_SQ: r_cfg.cutoff_sq <= i_cfg_data;
                CFG_SIGMA_SQ:  r_cfg.sigma_sq  <= i_cfg_data;
                default:       r_cfg.sigma_sq  <= r_cfg.sigma_sq;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        if (i_req_type == REQ_PAIR && a_ok && b_ok) begin
                            r_state <= T_PB;
                        end else if (i_req_type == REQ_READ && a_ok) begin
                            r_state <= T_RD;
                        end
                    end
                end
                T_PB:     r_state <= T_MSTART;
                T_MSTART: r_state <= T_MWAIT;
                T_MWAIT: begin
                    if (math_done) begin
                        r_state <= math_res.update ? T_FI : T_IDLE;
                    end
                end
                T_FI:     r_state <= T_FJ;
                T_FJ:     r_state <= T_IDLE;
                T_RD: begin
                    if (out_load) begin
                        r_state <= T_IDLE;
                    end
                end
                default:  r_state <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= i_atom_a;
            r_b <= i_atom_b;
        end
        if (r_state == T_PB) begin
            r_pos_a <= pos_rd;
        end
        if (math_done) begin
            r_res <= math_res;
        end
        if (out_load) begin
            r_out_idx <= r_a;
            r_out     <= force_rd;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_atom_index      = r_out_idx;
    assign o_force_x         = r_out.x;
    assign o_force_y         = r_out.y;
    assign o_force_z         = r_out.z;
    assign o_force_saturated = r_out.sat;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the Lennard-Jones pair force accumulator.
`timescale 1ns / 1ps

module testbench;
    import ljpf_pkg::*;

    localparam int  NATOMS      = 4096;
    localparam int  POOL_SIZE   = 32;
    localparam int  DRAIN_WAIT  = 400;
    localparam int  QUIET_LIMIT = 20000;
    localparam longint FORCE_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint FORCE_LO = -64'sh0000_8000_0000_0000;
    localparam logic [30:0] DEF_BOX   = 31'd100663296;
    localparam logic [30:0] DEF_INV   = 31'd2796203;
    localparam logic [30:0] DEF_CUT   = 31'd16777216;
    localparam logic [30:0] DEF_SIGMA = 31'd1509949;
    localparam logic [1:0]  REQ_UNKNOWN = 2'd3;

    typedef struct {
        logic [11:0] atom;
        logic [47:0] fx;
        logic [47:0] fy;
        logic [47:0] fz;
        logic        sat;
    } force_reading_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type = REQ_LOAD;
    logic [11:0] i_atom_a = '0;
    logic [11:0] i_atom_b = '0;
    logic [31:0] i_pos_x = '0;
    logic [31:0] i_pos_y = '0;
    logic [31:0] i_pos_z = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic [11:0] o_atom_index;
    logic [47:0] o_force_x;
    logic [47:0] o_force_y;
    logic [47:0] o_force_z;
    logic        o_force_saturated;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = CFG_BOX_X;
    logic [30:0] i_cfg_data = '0;

    lj_pair_force_accumulator_top DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Block state as the predictor sees it.
    logic [30:0] cfg_regs [8];
    int          pos_mem [NATOMS][3];
    longint      force_mem [NATOMS][3];
    bit          sat_mem [NATOMS];
    bit          loaded [NATOMS];
    logic [11:0] atom_pool [POOL_SIZE];

    force_reading_t expected_readings [$];

    int  n_errors = 0;
    int  n_loads = 0, n_pairs = 0, n_reads = 0, n_ignored = 0, n_checked = 0;
    int  n_settings = 0;
    bit  quiet = 1'b0;
    int  in_idle_pct = 25;
    int  quiet_cycles = 0;

    // Product shifted right, capped at the largest signed 64-bit value.
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        return (p > {64'd0, CAP64}) ? CAP64 : p[63:0];
    endfunction

    function automatic longint wrap_displacement(longint d, logic [30:0] box,
                                                 logic [30:0] inv);
        bit                neg;
        longint unsigned   mag, n;
        longint            r;
        neg = d < 0;
        mag = neg ? -d : d;
        n = (mag * inv + (64'd1 << 47)) >> 48;
        r = longint'(mag) - longint'(n * box);
        return neg ? -r : r;
    endfunction

    function automatic longint clamp_force(longint acc, longint v, ref bit clamped);
        longint s;
        s = acc + v;
        if (s > FORCE_HI) begin
            clamped = 1'b1;
            return FORCE_HI;
        end
        if (s < FORCE_LO) begin
            clamped = 1'b1;
            return FORCE_LO;
        end
        return s;
    endfunction

    task automatic apply_pair_force(int i, int j);
        longint          d [3];
        longint          f [3];
        logic [63:0]     mag [3];
        bit              neg [3];
        logic [63:0]     rsq, r2, ir, s2, s6, two, b, a, ab, fr, m;
        bit              huge, frneg, clamp, ci, cj;
        rsq = 0; fr = 0;
        huge = 0; frneg = 0; clamp = 0; ci = 0; cj = 0;
        for (int k = 0; k < 3; k++) begin
            d[k] = wrap_displacement(longint'(pos_mem[i][k]) - longint'(pos_mem[j][k]),
                                     cfg_regs[k], cfg_regs[k + 3]);
            neg[k] = d[k] < 0;
            mag[k] = neg[k] ? -d[k] : d[k];
            if (mag[k] >= (64'd1 << 28)) return;
            rsq += mag[k] * mag[k];
        end
        r2 = rsq >> 24;
        if (r2 == 0 || r2 >= cfg_regs[CFG_CUTOFF_SQ]) return;
        ir = (64'd1 << 56) / r2;
        s2 = scaled_product(cfg_regs[CFG_SIGMA_SQ], ir, 24);
        if (s2 >= S2_LIMIT) begin
            huge = 1;
        end else begin
            s6 = scaled_product(scaled_product(s2, s2, 32), s2, 32);
            two = s6 << 1;
            if (two >= 64'h1_0000_0000) begin
                b = two - 64'h1_0000_0000;
            end else begin
                b = 64'h1_0000_0000 - two;
                frneg = 1;
            end
            a = scaled_product(s6, ir, 48);
            ab = scaled_product(a, b, 32);
            if (ab > CAP64 / 12) begin
                huge = 1;
                frneg = 0;
            end else begin
                fr = ab * 12;
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (mag[k] == 0) begin
                m = 0;
            end else if (huge) begin
                m = FORCE_HI;
                clamp = 1;
            end else begin
                m = scaled_product(fr, mag[k], 16);
                if (m > FORCE_HI) begin
                    m = FORCE_HI;
                    clamp = 1;
                end
            end
            f[k] = (neg[k] != frneg) ? -longint'(m) : longint'(m);
        end
        for (int k = 0; k < 3; k++) force_mem[i][k] = clamp_force(force_mem[i][k], f[k], ci);
        for (int k = 0; k < 3; k++) force_mem[j][k] = clamp_force(force_mem[j][k], -f[k], cj);
        if (clamp || ci) sat_mem[i] = 1;
        if (clamp || cj) sat_mem[j] = 1;
    endtask

    task automatic predict_item(logic [1:0] req, logic [11:0] a, logic [11:0] b,
                                logic [31:0] x, logic [31:0] y, logic [31:0] z);
        force_reading_t rd;
        case (req)
            REQ_LOAD: begin
                pos_mem[a][0] = x;
                pos_mem[a][1] = y;
                pos_mem[a][2] = z;
                for (int k = 0; k < 3; k++) force_mem[a][k] = 0;
                sat_mem[a] = 0;
                loaded[a] = 1;
                n_loads++;
            end
            REQ_PAIR: begin
                apply_pair_force(a, b);
                n_pairs++;
            end
            REQ_READ: begin
                rd.atom = a;
                rd.fx = force_mem[a][0][47:0];
                rd.fy = force_mem[a][1][47:0];
                rd.fz = force_mem[a][2][47:0];
                rd.sat = sat_mem[a];
                expected_readings.push_back(rd);
                n_reads++;
            end
            default: n_ignored++;
        endcase
    endtask

    // Sends one item; the caller is always at a rising edge.
    task automatic send_item(logic [1:0] req, logic [11:0] a, logic [11:0] b,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_atom_a <= a;
        i_atom_b <= b;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        do @(posedge i_clk); while (!o_in_ready);
        predict_item(req, a, b, x, y, z);
    endtask

    task automatic load_atom(logic [11:0] a, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
        send_item(REQ_LOAD, a, 12'($urandom), x, y, z);
    endtask

    task automatic pair_atoms(logic [11:0] a, logic [11:0] b);
        send_item(REQ_PAIR, a, b, $urandom, $urandom, $urandom);
    endtask

    task automatic read_atom(logic [11:0] a);
        send_item(REQ_READ, a, 12'($urandom), $urandom, $urandom, $urandom);
    endtask

    // Lets all outstanding work finish; pairs give no beat, so a fixed pause follows.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_readings.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_settings(logic [30:0] box, logic [30:0] inv, logic [30:0] cut,
                                  logic [30:0] sigma);
        logic [30:0] vals [8];
        wait_idle();
        vals = '{box, box, box, inv, inv, inv, cut, sigma};
        for (int r = 0; r < 8; r++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= r[2:0];
            i_cfg_data <= vals[r];
            cfg_regs[r] = vals[r];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    task automatic test_loads_and_reads();
        load_atom(12'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        load_atom(12'd4095, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        read_atom(12'd0);
        read_atom(12'd4095);
        send_item(REQ_UNKNOWN, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        pair_atoms(12'd0, 12'd4095);
        read_atom(12'd4095);
    endtask

    task automatic test_pair_cases();
        load_atom(12'd1, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
        load_atom(12'd2, 32'h0180_0000, 32'h0100_0000, 32'h0100_0000);
        load_atom(12'd3, 32'h0100_0000, 32'h0140_0000, 32'h0100_0000);
        load_atom(12'd4, 32'h05D0_0000, 32'h0100_0000, 32'h0100_0000);
        load_atom(12'd5, 32'h0100_2000, 32'h0100_0000, 32'h0100_0000);
        pair_atoms(12'd1, 12'd2);    // attractive, half a unit apart
        pair_atoms(12'd1, 12'd3);    // repulsive, a quarter apart
        pair_atoms(12'd1, 12'd1);    // same atom, nothing happens
        pair_atoms(12'd4, 12'd1);    // pair across the periodic boundary, still beyond the cutoff
        pair_atoms(12'd1, 12'd5);    // far too close: force out of range
        pair_atoms(12'd1, 12'd5);    // pushes atom 1 into accumulator saturation
        pair_atoms(12'd0, 12'd1);    // beyond the cutoff
        for (int a = 1; a <= 5; a++) read_atom(a[11:0]);
    endtask

    task automatic test_setting_extremes();
        write_settings(31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        pair_atoms(12'd1, 12'd2);
        pair_atoms(12'd0, 12'd4095); // displacement too large to interact
        pair_atoms(12'd2, 12'd3);
        read_atom(12'd2);
        read_atom(12'd3);
        write_settings(31'd0, 31'h7FFF_FFFF, 31'd0, 31'd0);
        pair_atoms(12'd1, 12'd2);
        read_atom(12'd1);
        write_settings(DEF_BOX, DEF_INV, DEF_CUT, 31'd0);
        pair_atoms(12'd2, 12'd3);    // zero sigma gives a zero attractive term
        read_atom(12'd2);
    endtask

    task automatic random_items(int n_items, logic [30:0] box);
        longint      centre [3];
        longint      v;
        logic [31:0] p [3];
        logic [11:0] a, b;
        int          pick;
        for (int k = 0; k < 3; k++) centre[k] = $urandom_range(0, 32'h7FFF_FFFF) % (box + 1);
        for (int it = 0; it < n_items; it++) begin
            pick = $urandom_range(0, 99);
            a = atom_pool[$urandom_range(0, POOL_SIZE - 1)];
            b = atom_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (pick < 35 || !loaded[a] || (pick < 75 && !loaded[b])) begin
                for (int k = 0; k < 3; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        p[k] = $urandom;
                    end else begin
                        v = centre[k] + longint'($urandom_range(0, 32'h0200_0000))
                            - 64'sh0100_0000 + longint'($urandom_range(0, 2) - 1) * box;
                        p[k] = v[31:0];
                    end
                end
                load_atom(a, p[0], p[1], p[2]);
            end else if (pick < 75) begin
                pair_atoms(a, ($urandom_range(0, 19) == 0) ? a : b);
            end else if (pick < 95) begin
                read_atom(a);
            end else begin
                send_item(REQ_UNKNOWN, 12'($urandom), 12'($urandom), $urandom, $urandom,
                          $urandom);
            end
        end
    endtask

    task automatic test_random_settings();
        logic [30:0] box, inv, cut, sigma;
        for (int ph = 0; ph < 6; ph++) begin
            box = 31'(($urandom_range(2, 32) << 24) | $urandom_range(0, 24'hFF_FFFF));
            inv = 31'((64'd1 << 48) / box);
            cut = 31'($urandom_range(32'h0040_0000, 32'h0400_0000));
            sigma = 31'($urandom_range(32'h0010_0000, 32'h0080_0000));
            if (ph == 5) begin
                box = 31'($urandom);
                inv = 31'($urandom);
                cut = 31'($urandom);
                sigma = 31'($urandom);
            end
            in_idle_pct = (ph % 2) ? 30 : 0;
            write_settings(box, inv, cut, sigma);
            random_items(220, box);
        end
    endtask

    task automatic test_steady_stream();
        write_settings(DEF_BOX, DEF_INV, DEF_CUT, DEF_SIGMA);
        random_items(150, DEF_BOX);
        quiet = 1'b1;
        random_items(150, DEF_BOX);
    endtask

    // Receiver stalls in bursts.
    int out_hold = 0;
    always @(posedge i_clk) begin
        if (quiet) begin
            i_out_ready <= 1'b1;
        end else if (out_hold > 0) begin
            out_hold <= out_hold - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            out_hold <= $urandom_range(1, 12);
        end else begin
            i_out_ready <= 1'b1;
            out_hold <= $urandom_range(0, 20);
        end
    end

    always @(posedge i_clk) begin
        force_reading_t ex;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_readings.size() == 0) begin
                $error("force beat for atom %0d with none expected", o_atom_index);
                n_errors++;
            end else begin
                ex = expected_readings.pop_front();
                n_checked++;
                if (o_atom_index !== ex.atom) begin
                    $error("atom_index: expected %0d, got %0d", ex.atom, o_atom_index);
                    n_errors++;
                end
                if (o_force_x !== ex.fx) begin
                    $error("force_x: expected %h, got %h", ex.fx, o_force_x);
                    n_errors++;
                end
                if (o_force_y !== ex.fy) begin
                    $error("force_y: expected %h, got %h", ex.fy, o_force_y);
                    n_errors++;
                end
                if (o_force_z !== ex.fz) begin
                    $error("force_z: expected %h, got %h", ex.fz, o_force_z);
                    n_errors++;
                end
                if (o_force_saturated !== ex.sat) begin
                    $error("force_saturated: expected %0d, got %0d", ex.sat,
                           o_force_saturated);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cfg_regs = '{DEF_BOX, DEF_BOX, DEF_BOX, DEF_INV, DEF_INV, DEF_INV, DEF_CUT,
                     DEF_SIGMA};
        atom_pool[0] = 12'd0;
        atom_pool[1] = 12'd4095;
        for (int k = 2; k < POOL_SIZE; k++) atom_pool[k] = 12'($urandom);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_loads_and_reads();
        test_pair_cases();
        test_setting_extremes();
        test_random_settings();
        test_steady_stream();
        wait_idle();
        if (expected_readings.size() != 0) begin
            $error("%0d force readings never arrived", expected_readings.size());
            n_errors++;
        end
        $display("Ran %0d loads, %0d pairs, %0d reads and %0d ignored items", n_loads,
                 n_pairs, n_reads, n_ignored);
        $display("over %0d register settings; %0d force readings checked", n_settings,
                 n_checked);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
